// ===== src/lnf_pkg.sv =====
// Shared constants, types and helpers for the layer normalization forward core.
// Used by lnf_div, layer_norm_forward_core and the testbench; depends on nothing.
package lnf_pkg;

    localparam int MAX_ROW    = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int X_W        = 16;
    localparam int SUM_W      = 23;
    localparam int D_W        = 17;
    localparam int SQ_W       = 41;
    localparam int RSTD_W     = 32;
    localparam int DVD_W      = 49;
    localparam int DVS_W      = 41;
    localparam int DIV_CNT_W  = 6;
    localparam int P1_W       = 50;
    localparam int XW_W       = 34;
    localparam int P2_W       = 50;
    localparam int Y_W        = 43;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 1'b1;

    localparam logic [CNT_W-1:0]  ROW_LENGTH_RST = 7'd64;
    localparam logic [15:0]       EPSILON_RST    = 16'd1;
    localparam logic [DVD_W-1:0]  ONE_Q48        = {1'b1, {(DVD_W-1){1'b0}}};
    localparam logic [RSTD_W-1:0] RSTD_SAT       = {RSTD_W{1'b1}};

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

    // clamp a signed value to the signed Q8.8 range
    function automatic logic signed [X_W-1:0] sat16(input logic signed [Y_W-1:0] v);
        logic signed [X_W-1:0] r;
        if (v > $signed(43'sd32767))
            r = 16'sh7FFF;
        else if (v < -$signed(43'sd32768))
            r = 16'sh8000;
        else
            r = v[X_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/lnf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lnf_pkg.
module lnf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lnf_pkg::t_div_req i_req,
    output lnf_pkg::t_div_rsp o_rsp
);
    import lnf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W:0]       n_shift;
    logic                 n_qbit;
    logic [DVS_W:0]       n_diff;

    // trial subtract of the shifted partial remainder
    always_comb begin
        n_shift = {r_rem, r_dvd[DVD_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_qbit  = (n_shift >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], n_qbit};
            r_rem <= n_qbit ? n_diff[DVS_W-1:0] : n_shift[DVS_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== src/layer_norm_forward_core.sv =====
// Layer normalization forward core: row store, statistics sequencer and emit pipeline.
// Depends on lnf_pkg and lnf_div.
//
// Elements are taken one per cycle while o_busy is low (start high). The transaction
// that completes a row raises o_busy. The core then finds the mean with the shared
// serial divider. It sweeps the row memory for the squared deviations and divides for
// the variance and for 2^48/v. It takes the integer square root and sweeps the memory
// again, producing one result per cycle on o_valid through the read, rstd, gamma and
// output registers. When variance plus epsilon is zero, the reciprocal division and
// the square root are skipped and inv_std saturates. Results cannot be held off by the
// receiver: each is present for exactly one cycle. Configuration may be written only
// while idle.
module layer_norm_forward_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [lnf_pkg::X_W-1:0]    i_x_value,
    input  logic signed [lnf_pkg::X_W-1:0]    i_gamma_value,
    input  logic signed [lnf_pkg::X_W-1:0]    i_beta_value,
    input  logic                              i_cfg_we,
    input  logic [lnf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lnf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic signed [lnf_pkg::X_W-1:0]    o_y_value,
    output logic signed [lnf_pkg::X_W-1:0]    o_xhat_value,
    output logic [lnf_pkg::RSTD_W-1:0]        o_inv_std,
    output logic                              o_last_of_row
);
    import lnf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_VAR  = 3'd2;
    localparam logic [2:0] ST_DIVV = 3'd3;
    localparam logic [2:0] ST_DIVR = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    // configuration
    logic [CNT_W-1:0] r_row_length;
    logic [15:0]      r_epsilon;

    // control and row statistics
    logic [2:0]               r_state;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_n;
    logic                     r_sum_neg;
    logic signed [X_W-1:0]    r_mean;
    logic [CNT_W-1:0]         r_idx;
    logic [SQ_W-1:0]          r_sq_acc;
    logic [RSTD_W-1:0]        r_rstd;
    logic [DVD_W-1:0]         r_rt_n;
    logic [DVD_W-1:0]         r_rt_res;
    logic [DVD_W-1:0]         r_rt_bit;
    t_div_req                 r_div_req;
    t_div_rsp                 div_rsp;

    // row memory
    logic [3*X_W-1:0]         r_mem [MAX_ROW];
    logic [3*X_W-1:0]         r_rd_data;
    logic                     r_rd_v;
    logic                     r_rd_last;

    // pipeline stages
    logic                     r_sq_v;
    logic [2*D_W-1:0]         r_sq_prod;
    logic                     r_e1_v;
    logic                     r_e1_last;
    logic signed [P1_W-1:0]   r_e1_prod;
    logic signed [X_W-1:0]    r_e1_g;
    logic signed [X_W-1:0]    r_e1_b;
    logic                     r_e2_v;
    logic                     r_e2_last;
    logic signed [XW_W-1:0]   r_e2_xw;
    logic signed [P2_W-1:0]   r_e2_prod;
    logic signed [X_W-1:0]    r_e2_b;
    logic                     r_out_v;
    logic                     r_out_last;
    logic signed [X_W-1:0]    r_out_y;
    logic signed [X_W-1:0]    r_out_xhat;

    logic                     n_accept;
    logic [CNT_W-1:0]         n_len;
    logic [CNT_W-1:0]         n_count;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     n_close;
    logic [SUM_W-1:0]         n_sum_mag;
    logic                     n_issue;
    logic signed [D_W-1:0]    n_d;
    logic signed [SUM_W:0]    n_mean_q;
    logic [DVD_W-1:0]         n_v;
    logic [DVD_W-1:0]         n_rt_try;
    logic signed [XW_W-1:0]   n_xw;
    logic signed [Y_W-1:0]    n_y;

    lnf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign o_busy   = (r_state != ST_IDLE);
    assign n_accept = i_start && !o_busy;

    // clamp row length, count the incoming element, and form the deviation, mean, variance, root and emit terms
    always_comb begin
        if (r_row_length == '0)
            n_len = CNT_W'(1);
        else if (r_row_length > CNT_W'(MAX_ROW))
            n_len = CNT_W'(MAX_ROW);
        else
            n_len = r_row_length;
        n_count   = r_count + 1'b1;
        n_sum     = r_sum + SUM_W'(i_x_value);
        n_close   = (n_count >= n_len);
        n_sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        n_issue   = ((r_state == ST_VAR) || (r_state == ST_EMIT)) && (r_idx != r_n);
        n_d       = D_W'($signed(r_rd_data[3*X_W-1:2*X_W])) - D_W'(r_mean);
        n_mean_q  = $signed({2'b00, div_rsp.quotient[SUM_W-2:0]})
                    + $signed((SUM_W+1)'(div_rsp.remainder != '0));
        n_v       = div_rsp.quotient + DVD_W'(r_epsilon);
        n_rt_try  = r_rt_res + r_rt_bit;
        n_xw      = r_e1_prod[P1_W-1:16];
        n_y       = Y_W'($signed(r_e2_prod[P2_W-1:8])) + Y_W'(r_e2_b);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LENGTH_RST;
            r_epsilon    <= EPSILON_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_LENGTH: r_row_length <= i_cfg_data[CNT_W-1:0];
                REG_EPSILON:    r_epsilon    <= i_cfg_data;
                default:        r_row_length <= r_row_length;
            endcase
        end
    end

    // row memory: write on accept, read during the sweeps
    always_ff @(posedge i_clk) begin
        if (n_accept)
            r_mem[r_count[IDX_W-1:0]] <= {i_x_value, i_gamma_value, i_beta_value};
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_count         <= '0;
            r_sum           <= '0;
            r_div_req.start <= 1'b0;
            r_rd_v          <= 1'b0;
            r_idx           <= '0;
            r_n             <= '0;
        end else begin
            r_div_req.start <= 1'b0;
            r_rd_v          <= n_issue;
            r_rd_last       <= (r_idx == r_n - 1'b1);
            if (n_issue)
                r_idx <= r_idx + 1'b1;
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (n_close) begin
                            r_count            <= '0;
                            r_sum              <= '0;
                            r_n                <= n_count;
                            r_sum_neg          <= n_sum[SUM_W-1];
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= DVD_W'(n_sum_mag);
                            r_div_req.divisor  <= DVS_W'(n_count);
                            r_state            <= ST_MEAN;
                        end else begin
                            r_count <= n_count;
                            r_sum   <= n_sum;
                        end
                    end
                end
                ST_MEAN: begin
                    if (div_rsp.done) begin
                        r_mean   <= r_sum_neg ? X_W'(-n_mean_q)
                                              : X_W'(div_rsp.quotient);
                        r_idx    <= '0;
                        r_sq_acc <= '0;
                        r_state  <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (r_sq_v)
                        r_sq_acc <= r_sq_acc + SQ_W'(r_sq_prod);
                    if (!n_issue && !r_rd_v && !r_sq_v) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= DVD_W'(r_sq_acc);
                        r_div_req.divisor  <= DVS_W'(r_n);
                        r_state            <= ST_DIVV;
                    end
                end
                ST_DIVV: begin
                    if (div_rsp.done) begin
                        if (n_v == '0) begin
                            r_rstd  <= RSTD_SAT;
                            r_idx   <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= ONE_Q48;
                            r_div_req.divisor  <= n_v[DVS_W-1:0];
                            r_state            <= ST_DIVR;
                        end
                    end
                end
                ST_DIVR: begin
                    if (div_rsp.done) begin
                        r_rt_n   <= div_rsp.quotient;
                        r_rt_res <= '0;
                        r_rt_bit <= ONE_Q48;
                        r_state  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    // one bit pair of the integer square root per cycle
                    if (r_rt_bit != '0) begin
                        if (r_rt_n >= n_rt_try) begin
                            r_rt_n   <= r_rt_n - n_rt_try;
                            r_rt_res <= (r_rt_res >> 1) + r_rt_bit;
                        end else begin
                            r_rt_res <= r_rt_res >> 1;
                        end
                        r_rt_bit <= r_rt_bit >> 2;
                    end else begin
                        r_rstd  <= r_rt_res[RSTD_W-1:0];
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!n_issue && !r_rd_v && !r_e1_v && !r_e2_v)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_e1_v  <= 1'b0;
            r_e2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_sq_v  <= r_rd_v && (r_state == ST_VAR);
            r_e1_v  <= r_rd_v && (r_state == ST_EMIT);
            r_e2_v  <= r_e1_v;
            r_out_v <= r_e2_v;
        end
    end

    // datapath stages: square, scale by rstd, scale by gamma, shift and clamp
    always_ff @(posedge i_clk) begin
        r_sq_prod  <= (2*D_W)'(n_d * n_d);
        r_e1_prod  <= P1_W'(P1_W'(n_d) * $signed({{(P1_W-RSTD_W){1'b0}}, r_rstd}));
        r_e1_g     <= $signed(r_rd_data[2*X_W-1:X_W]);
        r_e1_b     <= $signed(r_rd_data[X_W-1:0]);
        r_e1_last  <= r_rd_last;
        r_e2_xw    <= n_xw;
        r_e2_prod  <= P2_W'(P2_W'(n_xw) * P2_W'(r_e1_g));
        r_e2_b     <= r_e1_b;
        r_e2_last  <= r_e1_last;
        r_out_y    <= sat16(n_y);
        r_out_xhat <= sat16(Y_W'(r_e2_xw));
        r_out_last <= r_e2_last;
    end

    assign o_valid       = r_out_v;
    assign o_y_value     = r_out_y;
    assign o_xhat_value  = r_out_xhat;
    assign o_inv_std     = r_rstd;
    assign o_last_of_row = r_out_last;

endmodule

// ===== sim/tb_layer_norm_forward_core.sv =====
// Self-checking testbench for layer_norm_forward_core: rows of elements in, normalized
// elements out, checked against an internal fixed-point predictor.
// Depends on lnf_pkg and the core RTL.
module tb_layer_norm_forward_core;
    import lnf_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] g;
        logic signed [15:0] b;
    } t_elem;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] xhat;
        logic [31:0]        rstd;
        logic               last;
    } t_norm;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [15:0] i_x_value = '0, i_gamma_value = '0, i_beta_value = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_busy, o_valid, o_last_of_row;
    logic signed [15:0] o_y_value, o_xhat_value;
    logic [31:0] o_inv_std;

    layer_norm_forward_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    int unsigned cur_len = 64;
    longint unsigned cur_eps = 1;
    t_elem row_buf[$];
    longint row_acc;

    t_elem pending_elems[$];
    t_norm expected_norms[$];
    int errors = 0;
    int results_seen = 0;
    int rows_done = 0;
    int send_idle_pct = 0;
    int accepted = 0;
    longint cycles = 0;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_q88(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // absorb one element; on row completion queue the normalized row
    task automatic normalize_element(t_elem e);
        int unsigned len;
        longint n, mean, d, xw, yv;
        longint unsigned sq, v, rstd;
        t_norm r;
        len = cur_len < 1 ? 1 : (cur_len > 64 ? 64 : cur_len);
        row_buf.push_back(e);
        row_acc += e.x;
        if (row_buf.size() < len) return;
        n = row_buf.size();
        mean = fdiv(row_acc, n);
        sq = 0;
        foreach (row_buf[i]) begin
            d = row_buf[i].x - mean;
            sq += d * d;
        end
        v = sq / n + cur_eps;
        rstd = (v == 0) ? 64'hFFFF_FFFF : int_sqrt((64'd1 << 48) / v);
        if (rstd > 64'hFFFF_FFFF) rstd = 64'hFFFF_FFFF;
        foreach (row_buf[i]) begin
            d = row_buf[i].x - mean;
            xw = fdiv(d * longint'(rstd), 65536);
            yv = fdiv(xw * row_buf[i].g, 256) + row_buf[i].b;
            r.y = 16'(sat_q88(yv));
            r.xhat = 16'(sat_q88(xw));
            r.rstd = rstd[31:0];
            r.last = (i == n - 1);
            expected_norms.push_back(r);
        end
        row_buf.delete();
        row_acc = 0;
        rows_done++;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
            results_seen);
        errors++;
    endtask

    // drive elements from the pending queue, idling at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                normalize_element({i_x_value, i_gamma_value, i_beta_value});
                accepted++;
            end
            if (i_start && o_busy) begin
                // hold current transaction
            end else if (pending_elems.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                t_elem e;
                e = pending_elems.pop_front();
                i_start <= 1'b1;
                i_x_value <= e.x;
                i_gamma_value <= e.g;
                i_beta_value <= e.b;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_valid) begin
            t_norm w;
            results_seen++;
            if (expected_norms.size() == 0) begin
                $display("unexpected result %0d", results_seen);
                errors++;
            end else begin
                w = expected_norms.pop_front();
                if (o_y_value !== w.y) report_mismatch("y", o_y_value, w.y);
                if (o_xhat_value !== w.xhat) report_mismatch("xhat", o_xhat_value, w.xhat);
                if (o_inv_std !== w.rstd) report_mismatch("inv_std", o_inv_std, w.rstd);
                if (o_last_of_row !== w.last) report_mismatch("last", o_last_of_row, w.last);
            end
        end
        if (cycles > 3_000_000) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_elem rand_elem();
        t_elem e;
        e.x = 16'($urandom);
        e.g = 16'($urandom);
        e.b = 16'($urandom);
        // pull x toward a narrow band half the time to keep xhat unsaturated
        if ($urandom_range(1)) e.x = 16'(int'($urandom_range(1023)) - 512);
        return e;
    endfunction

    // wait for all queued work and results, then let the core settle
    task automatic drain();
        wait (pending_elems.size() == 0);
        @(posedge i_clk);
        while (i_start || o_busy || expected_norms.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // one write strobe, then write enable low again so back-to-back writes stay apart
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ROW_LENGTH) cur_len = val[6:0];
        else cur_eps = val;
        @(posedge i_clk);
    endtask

    task automatic queue_rows(int count);
        for (int i = 0; i < count; i++) pending_elems.push_back(rand_elem());
    endtask

    initial begin
        t_elem e;
        int idle_pcts[4];
        idle_pcts = '{0, 61, 0, 38};
        row_acc = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset length 64 with extreme values
        for (int i = 0; i < 64; i++) begin
            e.x = (i % 2) ? 16'sh7FFF : 16'sh8000;
            e.g = (i % 3 == 0) ? 16'sh7FFF : 16'sh8000;
            e.b = (i % 4 == 0) ? 16'sh7FFF : 16'sh8000;
            pending_elems.push_back(e);
        end
        drain();
        // constant row with zero epsilon saturates inv_std
        write_reg(REG_EPSILON, 16'd0);
        write_reg(REG_ROW_LENGTH, 16'd4);
        for (int i = 0; i < 4; i++) pending_elems.push_back('{16'sd300, 16'sd256, 16'sd0});
        drain();
        // length zero acts as one; above range acts as the maximum
        write_reg(REG_ROW_LENGTH, 16'd0);
        pending_elems.push_back('{16'sh8000, 16'sh7FFF, 16'sh7FFF});
        pending_elems.push_back('{16'sh7FFF, 16'sh0001, 16'sh8000});
        drain();
        write_reg(REG_EPSILON, 16'hFFFF);
        write_reg(REG_ROW_LENGTH, 16'd127);
        queue_rows(64);
        drain();
        // lower length mid-row: row closes at next element
        write_reg(REG_ROW_LENGTH, 16'd8);
        queue_rows(5);
        drain();
        write_reg(REG_ROW_LENGTH, 16'd2);
        queue_rows(1);
        drain();

        // random phases with varied settings and sender idling
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = idle_pcts[ph % 4];
            write_reg(REG_EPSILON, ph == 3 ? 16'd0 : 16'($urandom));
            write_reg(REG_ROW_LENGTH, ph == 5 ? 16'd64 : 16'($urandom_range(12, 1)));
            queue_rows(ph == 5 ? 64 : 27);
            if (cur_len > 0 && cur_len < 64) begin
                // finish the row so nothing is left half-filled
                while ((row_buf.size() + pending_elems.size()) % cur_len != 0)
                    pending_elems.push_back(rand_elem());
            end
            drain();
        end

        $display("covered %0d elements in %0d rows, %0d results checked",
            accepted, rows_done, results_seen);
        if (errors == 0 && expected_norms.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== layer_norm_forward_core.f =====
src/lnf_pkg.sv
src/lnf_div.sv
src/layer_norm_forward_core.sv
sim/tb_layer_norm_forward_core.sv
